@@ sv/rational_arithmetic_unit_defines.svh @@
// ----------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// property checks for simulation, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// operation codes and fixed result widths of the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_ADD = 2'd0;
    localparam t_kind KIND_SUB = 2'd1;
    localparam t_kind KIND_MUL = 2'd2;
    localparam t_kind KIND_DIV = 2'd3;

    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

endpackage

`default_nettype wire

@@ sv/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// adds, subtracts, multiplies or divides two signed fractions and reduces the
// result to lowest terms, sign on the numerator
//
// input channel: i_valid / o_stall carry kind and the four operand fields;
// an item is taken when i_valid is high and o_stall is low. o_stall is high
// from the cycle after an item is taken until its result is loaded into the
// output register.
// output channel: o_valid / i_stall carry res_num, res_den and error.
// one shared multiplier forms the products, one shared subtractor then runs a
// binary gcd (one shift, subtract or swap per cycle) and two restoring
// divisions of P quotient bits each, P = 2*OPERAND_WIDTH. error items go
// straight to the output; zero results skip the gcd and the divisions.
// a finished result waits in the output register while i_stall is high; the
// unit accepts the next item once that result is loaded there, and only
// loads a newer result when the register is free or being taken.
// reset (synchronous, active low) clears the sequencer and o_valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_kind,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [NUM_W-1:0]        o_res_num,
    output logic [DEN_W-1:0]               o_res_den,
    output logic                           o_error
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int CW = $clog2(PW);
    localparam int XW = (PW > NUM_W) ? PW : NUM_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_COMB = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DIVN = 4'd6;
    localparam logic [3:0] S_DIVD = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        f_mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [3:0]    r_state, n_state;
    logic          r_out_valid;
    t_kind         r_kind, n_kind;
    logic [W-1:0]  r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic          r_san, n_san, r_sad, n_sad, r_sbn, n_sbn, r_sbd, n_sbd;
    logic [PW-1:0] r_p0, n_p0, r_p1, n_p1;
    logic          r_s0, n_s0, r_s1, n_s1, r_sden, n_sden;
    logic [PW-1:0] r_x, n_x, r_y, n_y, r_ns, n_ns, r_ds, n_ds;
    logic          r_neg, n_neg, r_err, n_err;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] prod;
    logic [PW:0]   sub_a, sub_b;
    logic [PW+1:0] sub_d;
    logic          borrow;
    logic [PW-1:0] q_cur;
    logic          in_err;
    logic          c_same, c_ge, c_sign;
    logic [PW-1:0] c_mag;
    logic          out_free;
    logic [XW-1:0] ext_n, ext_d, sgn_n;

    // shared multiplier
    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        unique case (r_state)
            S_MUL0: begin
                mul_a = r_an;
                mul_b = (r_kind == KIND_MUL) ? r_bn : r_bd;
            end
            S_MUL1: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            S_MUL2: begin
                mul_a = r_ad;
                mul_b = (r_kind == KIND_DIV) ? r_bn : r_bd;
            end
            default: begin
                mul_a = r_an;
                mul_b = r_bd;
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // shared subtractor: gcd compare or division trial
    assign q_cur = (r_state == S_DIVD) ? r_ds : r_ns;

    always_comb begin
        if (r_state == S_DIVN || r_state == S_DIVD) begin
            sub_a = {r_x, q_cur[PW-1]};
        end else begin
            sub_a = {1'b0, r_x};
        end
        sub_b = {1'b0, r_y};
    end

    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = sub_d[PW+1];

    assign in_err = (i_a_den == '0) || (i_b_den == '0) ||
                    ((i_kind == KIND_DIV) && (i_b_num == '0));

    // signed magnitude sum of the two cross products
    assign c_same = (r_s0 == r_s1);
    assign c_ge   = (r_p0 >= r_p1);
    assign c_mag  = c_same ? (r_p0 + r_p1) : (c_ge ? (r_p0 - r_p1) : (r_p1 - r_p0));
    assign c_sign = (c_same || c_ge) ? r_s0 : r_s1;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_an    = r_an;
        n_ad    = r_ad;
        n_bn    = r_bn;
        n_bd    = r_bd;
        n_san   = r_san;
        n_sad   = r_sad;
        n_sbn   = r_sbn;
        n_sbd   = r_sbd;
        n_p0    = r_p0;
        n_p1    = r_p1;
        n_s0    = r_s0;
        n_s1    = r_s1;
        n_sden  = r_sden;
        n_x     = r_x;
        n_y     = r_y;
        n_ns    = r_ns;
        n_ds    = r_ds;
        n_neg   = r_neg;
        n_err   = r_err;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind = i_kind;
                    n_an   = f_mag(i_a_num);
                    n_ad   = f_mag(i_a_den);
                    n_bn   = f_mag(i_b_num);
                    n_bd   = f_mag(i_b_den);
                    n_san  = i_a_num[W-1];
                    n_sad  = i_a_den[W-1];
                    n_sbn  = i_b_num[W-1];
                    n_sbd  = i_b_den[W-1];
                    if (in_err) begin
                        n_ns    = '0;
                        n_ds    = PW'(1);
                        n_neg   = 1'b0;
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_MUL0;
                    end
                end
            end
            S_MUL0: begin
                n_p0    = prod;
                n_s0    = r_san ^ ((r_kind == KIND_MUL) ? r_sbn : r_sbd);
                n_state = (r_kind == KIND_ADD || r_kind == KIND_SUB) ? S_MUL1 : S_MUL2;
            end
            S_MUL1: begin
                n_p1    = prod;
                n_s1    = r_sbn ^ r_sad ^ (r_kind == KIND_SUB);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_ds    = prod;
                n_sden  = r_sad ^ ((r_kind == KIND_DIV) ? r_sbn : r_sbd);
                n_state = S_COMB;
            end
            S_COMB: begin
                if (r_kind == KIND_ADD || r_kind == KIND_SUB) begin
                    n_x   = c_mag;
                    n_neg = c_sign ^ r_sden;
                end else begin
                    n_x   = r_p0;
                    n_neg = r_s0 ^ r_sden;
                end
                n_ns = n_x;
                n_y  = r_ds;
                if (n_x == '0) begin
                    n_ns    = '0;
                    n_ds    = PW'(1);
                    n_neg   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                priority if (r_x == '0) begin
                    n_cnt   = CW'(PW - 1);
                    n_state = S_DIVN;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x  = r_x >> 1;
                    n_y  = r_y >> 1;
                    n_ns = r_ns >> 1;
                    n_ds = r_ds >> 1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (borrow) begin
                    n_x = r_y;
                    n_y = r_x;
                end else begin
                    n_x = sub_d[PW-1:0];
                end
            end
            S_DIVN, S_DIVD: begin
                n_x = borrow ? sub_a[PW-1:0] : sub_d[PW-1:0];
                if (r_state == S_DIVN) begin
                    n_ns = {r_ns[PW-2:0], ~borrow};
                end else begin
                    n_ds = {r_ds[PW-2:0], ~borrow};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_x     = '0;
                    n_cnt   = CW'(PW - 1);
                    n_state = (r_state == S_DIVN) ? S_DIVD : S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_an   <= n_an;
        r_ad   <= n_ad;
        r_bn   <= n_bn;
        r_bd   <= n_bd;
        r_san  <= n_san;
        r_sad  <= n_sad;
        r_sbn  <= n_sbn;
        r_sbd  <= n_sbd;
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_s0   <= n_s0;
        r_s1   <= n_s1;
        r_sden <= n_sden;
        r_x    <= n_x;
        r_y    <= n_y;
        r_ns   <= n_ns;
        r_ds   <= n_ds;
        r_neg  <= n_neg;
        r_err  <= n_err;
        r_cnt  <= n_cnt;
    end

    // result formatting
    assign ext_n = XW'(r_ns);
    assign ext_d = XW'(r_ds);
    assign sgn_n = r_neg ? (~ext_n + 1'b1) : ext_n;

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_res_num <= sgn_n[NUM_W-1:0];
            o_res_den <= ext_d[DEN_W-1:0];
            o_error   <= r_err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_stall = (r_state != S_IDLE);

    `RAU_ASSERT_IMP(a_err_result, i_clk, i_rst_n, o_valid && o_error, (o_res_num == '0) && (o_res_den == DEN_W'(1)), "error item must read 0/1")
    `RAU_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, r_state != S_IDLE, "accepted item must start work")
    `RAU_ASSERT_IMP(a_div_rem, i_clk, i_rst_n, (r_state == S_DIVN) || (r_state == S_DIVD), r_x < r_y, "remainder must stay below gcd")
    `RAU_ASSERT_IMP(a_gcd_nonzero, i_clk, i_rst_n, r_state == S_GCD, r_y != '0, "gcd operand lost")
    `RAU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, (r_state == S_DONE) && !out_free, r_state == S_DONE, "result dropped while output busy")

endmodule

`default_nettype wire

@@ tb/rational_arithmetic_unit_checker.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_checker
// watches both channels of the rational arithmetic unit, computes the reduced
// fraction for every item taken and compares each result field by field
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker
    import rau_pkg::*;
#(
    parameter int OPW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [1:0]              i_kind,
    input  logic signed [OPW-1:0]   i_a_num,
    input  logic signed [OPW-1:0]   i_a_den,
    input  logic signed [OPW-1:0]   i_b_num,
    input  logic signed [OPW-1:0]   i_b_den,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [NUM_W-1:0] i_res_num,
    input  logic [DEN_W-1:0]        i_res_den,
    input  logic                    i_error,
    output int                      o_mismatches,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
        logic                    err;
    } t_fraction;

    t_fraction expected_fractions[$];
    int mismatches = 0;
    int checked    = 0;
    int flagged    = 0;
    int pending    = 0;

    assign o_mismatches = mismatches;
    assign o_checked    = checked;
    assign o_flagged    = flagged;
    assign o_pending    = pending;

    function automatic t_fraction reduce_fraction(
        input logic [1:0]            kind,
        input logic signed [OPW-1:0] an,
        input logic signed [OPW-1:0] ad,
        input logic signed [OPW-1:0] bn,
        input logic signed [OPW-1:0] bd
    );
        t_fraction      r;
        longint         num;
        longint         den;
        longint         signed_num;
        longint unsigned num_mag;
        longint unsigned den_mag;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        r.num = '0;
        r.den = DEN_W'(1);
        r.err = 1'b0;
        if (ad == 0 || bd == 0 || (kind == KIND_DIV && bn == 0)) begin
            r.err = 1'b1;
            return r;
        end
        case (kind)
            KIND_ADD: begin
                num = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
                den = longint'(ad) * longint'(bd);
            end
            KIND_SUB: begin
                num = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
                den = longint'(ad) * longint'(bd);
            end
            KIND_MUL: begin
                num = longint'(an) * longint'(bn);
                den = longint'(ad) * longint'(bd);
            end
            default: begin
                num = longint'(an) * longint'(bd);
                den = longint'(ad) * longint'(bn);
            end
        endcase
        if (num == 0) begin
            return r;
        end
        num_mag = (num < 0) ? longint'(-num) : longint'(num);
        den_mag = (den < 0) ? longint'(-den) : longint'(den);
        x = num_mag;
        y = den_mag;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        num_mag = num_mag / x;
        den_mag = den_mag / x;
        signed_num = ((num < 0) != (den < 0)) ? -longint'(num_mag) : longint'(num_mag);
        r.num = signed_num[NUM_W-1:0];
        r.den = den_mag[DEN_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        if (mismatches < 40) begin
            $display("[%0t] result %0d: %0s expected %0d, got %0d",
                     $time, checked, field, want, got);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_fraction want;
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_fractions.size() == 0) begin
                report_mismatch("unexpected res_num", 0, longint'(i_res_num));
            end else begin
                want = expected_fractions.pop_front();
                if (i_res_num !== want.num)
                    report_mismatch("res_num", longint'(want.num), longint'(i_res_num));
                if (i_res_den !== want.den)
                    report_mismatch("res_den", longint'(want.den), longint'(i_res_den));
                if (i_error !== want.err)
                    report_mismatch("error", longint'(want.err), longint'(i_error));
            end
            checked++;
            if (i_error)
                flagged++;
        end
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            expected_fractions.push_back(
                reduce_fraction(i_kind, i_a_num, i_a_den, i_b_num, i_b_den));
        end
        pending <= expected_fractions.size();
    end

endmodule

@@ tb/rational_arithmetic_unit_tb.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// drives directed and random fraction operations into the rational arithmetic
// unit under three idling patterns; a checker beside the unit predicts and
// compares every result
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int OPW             = 16;
    localparam int ITEMS_PER_PHASE = 650;
    localparam int SETTLE_CYCLES   = 200;
    localparam int CYCLE_LIMIT     = 1_500_000;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    i_stall = 1'b0;
    logic [1:0]              i_kind  = KIND_ADD;
    logic signed [OPW-1:0]   i_a_num = '0;
    logic signed [OPW-1:0]   i_a_den = '0;
    logic signed [OPW-1:0]   i_b_num = '0;
    logic signed [OPW-1:0]   i_b_den = '0;
    logic                    o_stall;
    logic                    o_valid;
    logic signed [NUM_W-1:0] o_res_num;
    logic [DEN_W-1:0]        o_res_den;
    logic                    o_error;

    int send_idle_pct = 13;
    int stall_pct     = 84;
    int cycle_count   = 0;
    int sent          = 0;
    int mismatches;
    int pending;
    int checked;
    int flagged;

    rational_arithmetic_unit #(
        .OPERAND_WIDTH(OPW)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_a_num  (i_a_num),
        .i_a_den  (i_a_den),
        .i_b_num  (i_b_num),
        .i_b_den  (i_b_den),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res_num(o_res_num),
        .o_res_den(o_res_den),
        .o_error  (o_error)
    );

    rational_arithmetic_unit_checker #(
        .OPW(OPW)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_kind      (i_kind),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_res_num   (o_res_num),
        .i_res_den   (o_res_den),
        .i_error     (o_error),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_flagged   (flagged)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_stall     <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic signed [OPW-1:0] pick_value();
        logic signed [OPW-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = OPW'(int'($urandom_range(32)) - 16);
            4, 5, 6:    v = OPW'($urandom);
            7: begin
                case ($urandom_range(4))
                    0:       v = {1'b1, {(OPW-1){1'b0}}};
                    1:       v = {1'b0, {(OPW-1){1'b1}}};
                    2:       v = '1;
                    3:       v = OPW'(1);
                    default: v = {1'b1, {(OPW-2){1'b0}}, 1'b1};
                endcase
            end
            8: begin
                v = OPW'((int'($urandom_range(7)) + 1) << $urandom_range(OPW-4));
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = OPW'(int'($urandom_range(60)) * 105 - 3150);
        endcase
        return v;
    endfunction

    function automatic logic signed [OPW-1:0] pick_den();
        logic signed [OPW-1:0] v;
        if ($urandom_range(39) == 0)
            return '0;
        v = pick_value();
        if (v == 0)
            v = OPW'(1);
        return v;
    endfunction

    task automatic send_item(
        input logic [1:0]            kind,
        input logic signed [OPW-1:0] an,
        input logic signed [OPW-1:0] ad,
        input logic signed [OPW-1:0] bn,
        input logic signed [OPW-1:0] bd
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic send_random_item();
        logic [1:0]            kind;
        logic signed [OPW-1:0] an;
        logic signed [OPW-1:0] ad;
        logic signed [OPW-1:0] bn;
        logic signed [OPW-1:0] bd;
        kind = 2'($urandom_range(3));
        an   = pick_value();
        ad   = pick_den();
        bn   = pick_value();
        bd   = pick_den();
        case ($urandom_range(15))
            0: begin
                bn = an;
                bd = ad;
            end
            1: begin
                bn = -an;
                bd = ad;
            end
            default: ;
        endcase
        send_item(kind, an, ad, bn, bd);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_item();
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(KIND_ADD, 1, 2, 1, 3);
        send_item(KIND_ADD, 3, -4, 1, 4);
        send_item(KIND_SUB, 1, 2, 1, 2);
        send_item(KIND_SUB, -32768, 1, 32767, 1);
        send_item(KIND_ADD, -32768, -32768, -32768, -32768);
        send_item(KIND_ADD, 32767, -32768, 32767, -32768);
        send_item(KIND_ADD, 32767, 32767, 32767, 32767);
        send_item(KIND_SUB, -1, -1, -1, 1);
        send_item(KIND_MUL, -32768, 1, -32768, 1);
        send_item(KIND_MUL, 32767, -32768, -32768, 32767);
        send_item(KIND_MUL, 0, 5, -7, 3);
        send_item(KIND_MUL, 12, -18, -27, 8);
        send_item(KIND_DIV, -32768, 1, 1, -32768);
        send_item(KIND_DIV, 1, -32768, -32768, 1);
        send_item(KIND_DIV, 32767, 1, -1, 1);
        send_item(KIND_DIV, 0, 3, 4, 9);
        send_item(KIND_DIV, 5, 7, 0, 3);
        send_item(KIND_DIV, 0, 7, 0, 3);
        send_item(KIND_ADD, 1, 0, 1, 1);
        send_item(KIND_SUB, 1, 1, 1, 0);
        send_item(KIND_MUL, 0, 0, 0, 0);
        wait_for_results();

        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 84;
        stall_pct     = 13;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(ITEMS_PER_PHASE);

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d items sent: directed extremes and error cases, then random operands",
                 sent);
        $display("%0d results checked under three idling patterns, %0d flagged as errors",
                 checked, flagged);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ rational_arithmetic_unit.f @@
+incdir+sv
sv/rau_pkg.sv
sv/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_checker.sv
tb/rational_arithmetic_unit_tb.sv
